// ===== rtl/atse_pkg.sv =====
// Package for the ASN.1 time string to epoch unit: widths, codes, types, tables.
// No dependencies.
package atse_pkg;

  localparam int unsigned MaxChars  = 32;
  localparam int unsigned SecsW     = 38;
  localparam int unsigned QueueDepth = 2;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_MALFORMED = 2'd1,
    ST_RANGE     = 2'd2,
    ST_EPOCH     = 2'd3
  } status_e;

  // Fields of one finished string, handed from front to back
  typedef struct packed {
    logic        utc;
    logic [2:0]  phase;
    logic [5:0]  digit_count;
    logic [13:0] year;
    logic [6:0]  month;
    logic [6:0]  day;
    logic [6:0]  hour;
    logic [6:0]  minute;
    logic [6:0]  second;
    logic        ofs_sign;
    logic [13:0] ofs;
    logic        err;
  } fields_t;

  function automatic logic [8:0] days_before(input logic [3:0] m);
    case (m)
      4'd0:    days_before = 9'd0;
      4'd1:    days_before = 9'd31;
      4'd2:    days_before = 9'd59;
      4'd3:    days_before = 9'd90;
      4'd4:    days_before = 9'd120;
      4'd5:    days_before = 9'd151;
      4'd6:    days_before = 9'd181;
      4'd7:    days_before = 9'd212;
      4'd8:    days_before = 9'd243;
      4'd9:    days_before = 9'd273;
      4'd10:   days_before = 9'd304;
      4'd11:   days_before = 9'd334;
      default: days_before = 9'd365;
    endcase
  endfunction

endpackage

// ===== rtl/atse_if.sv =====
// Valid/ready channel interfaces for the input characters and the results.
// Depends on atse_pkg.
interface atse_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] ch;
  logic       last;
  logic       two_digit_year;
  modport source (output valid, ch, last, two_digit_year, input ready);
  modport sink (input valid, ch, last, two_digit_year, output ready);
endinterface

interface atse_out_if;
  logic                      valid;
  logic                      ready;
  logic [atse_pkg::SecsW-1:0] seconds;
  logic [1:0]                status;
  modport source (output valid, seconds, status, input ready);
  modport sink (input valid, seconds, status, output ready);
endinterface

// ===== rtl/atse_front.sv =====
// Front: per-character parse, accumulates fields, emits a fields beat on last.
// Depends on atse_pkg.
module atse_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  output logic               ready_o,
  input  logic [7:0]         ch_i,
  input  logic               last_i,
  input  logic               two_digit_year_i,
  output logic               push_o,
  output atse_pkg::fields_t  fields_o,
  input  logic               full_i
);

  logic [5:0]  pos_q;
  logic [2:0]  phase_q, phase_d;
  logic [5:0]  dcnt_q, dcnt_d;
  logic [13:0] year_q, year_d, ofs_q, ofs_d;
  logic [6:0]  mon_q, mon_d, day_q, day_d, hr_q, hr_d, min_q, min_d, sec_q, sec_d;
  logic        sign_q, sign_d, err_q, err_d;
  logic        is_digit, take;
  logic [3:0]  dig;
  logic [6:0]  idx;

  assign ready_o  = !full_i;
  assign take     = valid_i && ready_o;
  assign is_digit = (ch_i >= 8'h30) && (ch_i <= 8'h39);
  assign dig      = 4'(ch_i - 8'h30);
  assign idx      = {1'b0, dcnt_q} + (two_digit_year_i ? 7'd2 : 7'd0);

  // Next field state for this character
  always_comb begin
    phase_d = phase_q; dcnt_d = dcnt_q; year_d = year_q; ofs_d = ofs_q;
    mon_d = mon_q; day_d = day_q; hr_d = hr_q; min_d = min_q; sec_d = sec_q;
    sign_d = sign_q;
    err_d = err_q | (32'(pos_q) + 32'd1 > atse_pkg::MaxChars);
    if (phase_q == 3'd0) begin
      if (is_digit) begin
        if (idx < 7'd4) year_d = 14'(year_q * 14'd10 + 14'(dig));
        else if (idx < 7'd6) mon_d = 7'(mon_q * 7'd10 + 7'(dig));
        else if (idx < 7'd8) day_d = 7'(day_q * 7'd10 + 7'(dig));
        else if (idx < 7'd10) hr_d = 7'(hr_q * 7'd10 + 7'(dig));
        else if (idx < 7'd12) min_d = 7'(min_q * 7'd10 + 7'(dig));
        else if (idx < 7'd14) sec_d = 7'(sec_q * 7'd10 + 7'(dig));
        if (dcnt_q != 6'd63) dcnt_d = dcnt_q + 6'd1;
      end else if (ch_i == 8'h5A) begin
        phase_d = 3'd1;
      end else if (ch_i == 8'h2B || ch_i == 8'h2D) begin
        sign_d  = (ch_i == 8'h2D);
        phase_d = 3'd2;
      end else begin
        err_d = 1'b1;
      end
    end else if (phase_q >= 3'd2 && phase_q <= 3'd5) begin
      if (is_digit) begin
        ofs_d   = 14'(ofs_q * 14'd10 + 14'(dig));
        phase_d = phase_q + 3'd1;
      end else begin
        err_d = 1'b1;
      end
    end else begin
      err_d = 1'b1;
    end
  end

  always_comb begin
    fields_o.utc = two_digit_year_i; fields_o.phase = phase_d;
    fields_o.digit_count = dcnt_d; fields_o.year = year_d;
    fields_o.month = mon_d; fields_o.day = day_d; fields_o.hour = hr_d;
    fields_o.minute = min_d; fields_o.second = sec_d;
    fields_o.ofs_sign = sign_d; fields_o.ofs = ofs_d; fields_o.err = err_d;
  end
  assign push_o = take && last_i;

  // Accumulators, cleared at the end of each string
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0; phase_q <= '0; dcnt_q <= '0; year_q <= '0; ofs_q <= '0;
      mon_q <= '0; day_q <= '0; hr_q <= '0; min_q <= '0; sec_q <= '0;
      sign_q <= 1'b0; err_q <= 1'b0;
    end else if (take) begin
      if (last_i) begin
        pos_q <= '0; phase_q <= '0; dcnt_q <= '0; year_q <= '0; ofs_q <= '0;
        mon_q <= '0; day_q <= '0; hr_q <= '0; min_q <= '0; sec_q <= '0;
        sign_q <= 1'b0; err_q <= 1'b0;
      end else begin
        if (pos_q != 6'd63) pos_q <= pos_q + 6'd1;
        phase_q <= phase_d; dcnt_q <= dcnt_d; year_q <= year_d; ofs_q <= ofs_d;
        mon_q <= mon_d; day_q <= day_d; hr_q <= hr_d; min_q <= min_d;
        sec_q <= sec_d; sign_q <= sign_d; err_q <= err_d;
      end
    end
  end

endmodule

// ===== rtl/atse_queue.sv =====
// Two-entry queue of finished field sets between front and back.
// Depends on atse_pkg.
module atse_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  atse_pkg::fields_t data_i,
  output logic              full_o,
  output logic              valid_o,
  input  logic              pop_i,
  output atse_pkg::fields_t data_o
);

  atse_pkg::fields_t mem_q [atse_pkg::QueueDepth];
  logic wp_q, rp_q;
  logic [1:0] cnt_q;

  assign full_o  = (cnt_q == 2'(atse_pkg::QueueDepth));
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= ~wp_q;
      if (pop_i) rp_q <= ~rp_q;
      cnt_q <= cnt_q + {1'b0, push_i} - {1'b0, pop_i};
    end
  end

endmodule

// ===== rtl/atse_back.sv =====
// Back: three-stage check and conversion to Unix seconds, output register.
// Depends on atse_pkg.
module atse_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  output logic              pop_o,
  input  atse_pkg::fields_t f_i,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [atse_pkg::SecsW-1:0] seconds_o,
  output logic [1:0]        status_o
);

  // Stage 1: format checks, year, day count
  logic        v1_q, v2_q, v3_q, adv1, adv2, adv3;
  logic        bad1_q, bad2_q;
  logic [1:0]  st1_q, st2_q;
  logic [22:0] days1_q;
  logic [6:0]  hr1_q, min1_q, sec1_q;
  logic        ofsv1_q;
  logic [12:0] xtra1_q, xtra2_q;
  logic        neg1_q, neg2_q, ofsv2_q;
  logic [26:0] days_h2_q;
  logic [11:0] ms2_q;

  logic [1:0]  st_c;
  logic [14:0] year_c;
  logic [13:0] yr_c;
  logic [22:0] days_c;
  logic [8:0]  md_c;
  logic        leap_c;
  logic [26:0] ofs_m_c;
  logic [6:0]  oh_c, om_c;
  logic [12:0] xm_c;

  assign adv3 = !v3_q || ready_i;
  assign adv2 = !v2_q || adv3;
  assign adv1 = !v1_q || adv2;
  assign pop_o = valid_i && adv1;

  always_comb begin
    st_c = atse_pkg::ST_OK;
    year_c = f_i.utc ? ((f_i.year < 14'd50) ? 15'(f_i.year) + 15'd2000
                                           : 15'(f_i.year) + 15'd1900)
                     : 15'(f_i.year);
    yr_c   = 14'(year_c - 15'd1970);
    leap_c = (year_c[1:0] == 2'b00);
    days_c = '0; md_c = '0;
    // hhmm split by reciprocal multiply, exact for four digits
    ofs_m_c = 27'(f_i.ofs) * 27'd5243;
    oh_c = ofs_m_c[25:19];
    om_c = 7'(f_i.ofs - 14'(oh_c) * 14'd100);
    xm_c = 13'(oh_c) * 13'd60 + 13'(om_c);
    if (f_i.err || (f_i.phase >= 3'd2 && f_i.phase <= 3'd5) || f_i.phase > 3'd6 ||
        (f_i.utc && f_i.phase == 3'd0) ||
        (f_i.utc && f_i.digit_count != 6'd10 && f_i.digit_count != 6'd12) ||
        (!f_i.utc && f_i.digit_count != 6'd12 && f_i.digit_count != 6'd14)) begin
      st_c = atse_pkg::ST_MALFORMED;
    end else if (year_c < 15'd1970) begin
      st_c = atse_pkg::ST_EPOCH;
    end else if (f_i.month < 7'd1 || f_i.month > 7'd12) begin
      st_c = atse_pkg::ST_RANGE;
    end else begin
      md_c = atse_pkg::days_before(f_i.month[3:0]) -
             atse_pkg::days_before(f_i.month[3:0] - 4'd1);
      if (f_i.month == 7'd2 && leap_c) md_c = md_c + 9'd1;
      days_c = 23'(yr_c) * 23'd365
             + 23'(atse_pkg::days_before(f_i.month[3:0] - 4'd1))
             + 23'((yr_c + 14'd2) >> 2) + 23'(f_i.day) - 23'd1
             - ((leap_c && f_i.month < 7'd3) ? 23'd1 : 23'd0);
      if (f_i.day < 7'd1 || 9'(f_i.day) > md_c || f_i.hour > 7'd23 ||
          f_i.minute > 7'd59 || f_i.second > 7'd59) st_c = atse_pkg::ST_RANGE;
      else if (f_i.phase == 3'd6 && (oh_c > 7'd23 || om_c > 7'd59 ||
               (!f_i.ofs_sign && xm_c > 13'd840) ||
               (f_i.ofs_sign && xm_c > 13'd720))) st_c = atse_pkg::ST_RANGE;
    end
  end

  logic [39:0] tot_c, sub_c;
  logic        neg_c;
  always_comb begin
    tot_c = 40'(days_h2_q) * 40'd3600 + 40'(ms2_q);
    sub_c = 40'(xtra2_q) * 40'd60;
    neg_c = 1'b0;
    if (ofsv2_q && !neg2_q) begin
      neg_c = tot_c < sub_c;
      tot_c = tot_c - sub_c;
    end else if (ofsv2_q) begin
      tot_c = tot_c + sub_c;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0;
    end else begin
      if (adv1) v1_q <= valid_i;
      if (adv2) v2_q <= v1_q;
      if (adv3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      st1_q <= st_c; bad1_q <= (st_c != atse_pkg::ST_OK);
      days1_q <= days_c; hr1_q <= f_i.hour; min1_q <= f_i.minute;
      sec1_q <= f_i.second; ofsv1_q <= (f_i.phase == 3'd6);
      xtra1_q <= xm_c; neg1_q <= f_i.ofs_sign;
    end
    if (adv2) begin
      st2_q <= st1_q; bad2_q <= bad1_q;
      days_h2_q <= 27'(days1_q) * 27'd24 + 27'(hr1_q);
      ms2_q <= 12'(min1_q) * 12'd60 + 12'(sec1_q);
      xtra2_q <= xtra1_q; neg2_q <= neg1_q; ofsv2_q <= ofsv1_q;
    end
    if (adv3) begin
      if (bad2_q) begin
        status_o <= st2_q; seconds_o <= '0;
      end else if (neg_c) begin
        status_o <= atse_pkg::ST_EPOCH; seconds_o <= '0;
      end else begin
        status_o <= atse_pkg::ST_OK; seconds_o <= tot_c[atse_pkg::SecsW-1:0];
      end
    end
  end
  assign valid_o = v3_q;

endmodule

// ===== rtl/asn1_time_string_to_epoch_unit.sv =====
// ASN.1 time string to Unix seconds. One character a cycle, back to back, while the queue is not full.
// Result: fields are queued when the last character is accepted, then registered through the back pipeline.
// Throughput: 1 character per cycle while the queue is not full; the 2-entry queue and back pipeline stall apart.
// Reset: asynchronous active low, clears parse state, queue and pipeline valids.
// Depends on atse_pkg, atse_if, atse_front, atse_queue, atse_back.
module asn1_time_string_to_epoch_unit (
  input  logic         clk_i,
  input  logic         rst_ni,
  atse_in_if.sink      in_i,
  atse_out_if.source   out_o
);

  logic              push, full, qv, pop;
  atse_pkg::fields_t fin, fout;

  atse_front u_front (
    .clk_i, .rst_ni, .valid_i(in_i.valid), .ready_o(in_i.ready), .ch_i(in_i.ch),
    .last_i(in_i.last), .two_digit_year_i(in_i.two_digit_year),
    .push_o(push), .fields_o(fin), .full_i(full)
  );

  atse_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .data_i(fin), .full_o(full),
    .valid_o(qv), .pop_i(pop), .data_o(fout)
  );

  atse_back u_back (
    .clk_i, .rst_ni, .valid_i(qv), .pop_o(pop), .f_i(fout),
    .valid_o(out_o.valid), .ready_i(out_o.ready),
    .seconds_o(out_o.seconds), .status_o(out_o.status)
  );

endmodule
